// ----- rtl/i2cm_pkg.sv -----
// Shared types and constants for the I2C master byte engine.
// No dependencies; the top, i2cm_cfg and i2cm_core import this package.
package i2cm_pkg;

	localparam logic [7:0] DELAY_TICKS_RST = 8'd10;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd50;

	localparam int unsigned PADDR_W = 3;

	localparam logic REG_DELAY_TICKS = 1'b0;
	localparam logic REG_ACK_TIMEOUT = 1'b1;

	localparam logic [2:0] FUNC_NONE      = 3'd0;
	localparam logic [2:0] FUNC_START     = 3'd1;
	localparam logic [2:0] FUNC_STOP      = 3'd2;
	localparam logic [2:0] FUNC_WRITE     = 3'd3;
	localparam logic [2:0] FUNC_READ_ACK  = 3'd4;
	localparam logic [2:0] FUNC_READ_NACK = 3'd5;

	typedef enum logic [18:0] {
		PH_IDLE   = 19'h00001,
		PH_S_A    = 19'h00002,
		PH_S_B    = 19'h00004,
		PH_S_C    = 19'h00008,
		PH_P_A    = 19'h00010,
		PH_P_B    = 19'h00020,
		PH_P_C    = 19'h00040,
		PH_P_D    = 19'h00080,
		PH_W_BIT  = 19'h00100,
		PH_W_HI   = 19'h00200,
		PH_W_LO   = 19'h00400,
		PH_A_REL  = 19'h00800,
		PH_A_HI   = 19'h01000,
		PH_A_POLL = 19'h02000,
		PH_R_LO   = 19'h04000,
		PH_R_HI   = 19'h08000,
		PH_K_DATA = 19'h10000,
		PH_K_HI   = 19'h20000,
		PH_K_END  = 19'h40000
	} phase_t;

	typedef struct packed {
		logic [7:0] delay_ticks;
		logic [7:0] ack_timeout;
	} cfg_t;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] tx_byte;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic       ok;
		logic [7:0] rx_byte;
	} res_t;

endpackage

// ----- rtl/i2cm_in_if.sv -----
// Command/tick channel into the I2C master byte engine.
// Standalone; valid/ready handshake with the tick payload.
interface i2cm_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [7:0] tx_byte;
	logic       sda_in;

	modport source (output valid, func, tx_byte, sda_in, input ready);
	modport sink (input valid, func, tx_byte, sda_in, output ready);
endinterface

// ----- rtl/i2cm_out_if.sv -----
// Result channel out of the I2C master byte engine.
// Standalone; valid/ready handshake with pin levels and status.
interface i2cm_out_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic       ok;
	logic [7:0] rx_byte;

	modport source (output valid, scl_out, sda_out, sda_drive, busy_res, done_res, ok,
		rx_byte, input ready);
	modport sink (input valid, scl_out, sda_out, sda_drive, busy_res, done_res, ok,
		rx_byte, output ready);
endinterface

// ----- rtl/i2c_master_byte_engine_top.sv -----
// Top level of the I2C master byte engine: input register, sequencer, result register.
// Depends on i2cm_pkg, i2cm_in_if, i2cm_out_if, i2cm_cfg, i2cm_core.
// Each input transaction is one bus timing tick and yields exactly one result
// transaction carrying SCL/SDA levels, SDA drive enable and command status.
// Throughput is one tick per clock while the result side accepts; each tick is held
// in the input register, then the result register, with the sequencer step between them.
// Output backpressure stalls the input side once both registers hold data.
// Configuration writes go through the APB port and take effect on the next tick.
module i2c_master_byte_engine_top (
	input  logic                          clk,
	input  logic                          arst_n,
	i2cm_in_if.sink                       in_ch,
	i2cm_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [i2cm_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import i2cm_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  vld_s1;
	res_t  res;
	res_t  res_q;
	logic  res_vld_q;
	logic  adv;
	logic  in_acc;

	assign adv          = vld_s1 && (!res_vld_q || out_ch.ready);
	assign in_ch.ready  = !vld_s1 || adv;
	assign in_acc       = in_ch.valid && in_ch.ready;

	i2cm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	i2cm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			vld_s1    <= in_acc || (vld_s1 && !adv);
			res_vld_q <= adv || (res_vld_q && !out_ch.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.func    <= in_ch.func;
			item_s1.tx_byte <= in_ch.tx_byte;
			item_s1.sda_in  <= in_ch.sda_in;
		end
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_ch.valid     = res_vld_q;
	assign out_ch.scl_out   = res_q.scl_out;
	assign out_ch.sda_out   = res_q.sda_out;
	assign out_ch.sda_drive = res_q.sda_drive;
	assign out_ch.busy_res  = res_q.busy_res;
	assign out_ch.done_res  = res_q.done_res;
	assign out_ch.ok        = res_q.ok;
	assign out_ch.rx_byte   = res_q.rx_byte;
endmodule

// ----- rtl/i2cm_cfg.sv -----
// APB-style register port: delay_ticks and ack_timeout.
// Depends on i2cm_pkg.
module i2cm_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [i2cm_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output i2cm_pkg::cfg_t                cfg
);
	import i2cm_pkg::*;

	cfg_t cfg_q;
	logic wr;
	logic idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_ticks <= DELAY_TICKS_RST;
			cfg_q.ack_timeout <= ACK_TIMEOUT_RST;
		end else if (wr) begin
			case (idx)
				REG_DELAY_TICKS: cfg_q.delay_ticks <= pwdata[7:0];
				REG_ACK_TIMEOUT: cfg_q.ack_timeout <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DELAY_TICKS: prdata = {24'd0, cfg_q.delay_ticks};
			REG_ACK_TIMEOUT: prdata = {24'd0, cfg_q.ack_timeout};
			default:         prdata = 32'd0;
		endcase
	end
endmodule

// ----- rtl/i2cm_core.sv -----
// Bus sequencer state and the one-tick step logic.
// Depends on i2cm_pkg; state advances only when step is high.
module i2cm_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  i2cm_pkg::item_t item,
	input  i2cm_pkg::cfg_t  cfg,
	output i2cm_pkg::res_t  res
);
	import i2cm_pkg::*;

	phase_t     phase_q, n_phase, tgt;
	logic [3:0] bc_q, n_bc;
	logic [7:0] shift_q, n_shift;
	logic [7:0] dcnt_q, n_dcnt;
	logic [1:0] unit_q, n_unit;
	logic [7:0] poll_q, n_poll;
	logic       scl_q, n_scl;
	logic       sda_q, n_sda;
	logic       drv_q, n_drv;
	logic       sack_q, n_sack;
	logic       do_enter;
	logic       done, okv;
	logic [7:0] rx;
	logic [7:0] ulen;

	function automatic phase_t successor(input phase_t ph, input logic [3:0] bc);
		case (ph)
			PH_S_A:    successor = PH_S_B;
			PH_S_B:    successor = PH_S_C;
			PH_P_A:    successor = PH_P_B;
			PH_P_B:    successor = PH_P_C;
			PH_P_C:    successor = PH_P_D;
			PH_W_BIT:  successor = PH_W_HI;
			PH_W_HI:   successor = PH_W_LO;
			PH_W_LO:   successor = (bc >= 4'd8) ? PH_A_REL : PH_W_BIT;
			PH_A_REL:  successor = PH_A_HI;
			PH_A_HI:   successor = PH_A_POLL;
			PH_A_POLL: successor = PH_A_POLL;
			PH_R_LO:   successor = PH_R_HI;
			PH_R_HI:   successor = (bc >= 4'd8) ? PH_K_DATA : PH_R_LO;
			PH_K_DATA: successor = PH_K_HI;
			PH_K_HI:   successor = PH_K_END;
			default:   successor = PH_IDLE;
		endcase
	endfunction

	assign ulen = (cfg.delay_ticks == 8'd0) ? 8'd1 : cfg.delay_ticks;

	always_comb begin
		n_phase  = phase_q;
		n_bc     = bc_q;
		n_shift  = shift_q;
		n_dcnt   = dcnt_q;
		n_unit   = unit_q;
		n_poll   = poll_q;
		n_scl    = scl_q;
		n_sda    = sda_q;
		n_drv    = drv_q;
		n_sack   = sack_q;
		done     = 1'b0;
		okv      = 1'b0;
		rx       = 8'd0;
		do_enter = 1'b0;
		tgt      = PH_IDLE;

		if (phase_q == PH_IDLE) begin
			case (item.func)
				FUNC_START: begin
					do_enter = 1'b1;
					tgt      = PH_S_A;
				end
				FUNC_STOP: begin
					n_sack   = 1'b1;
					do_enter = 1'b1;
					tgt      = PH_P_A;
				end
				FUNC_WRITE: begin
					n_drv    = 1'b1;
					n_scl    = 1'b0;
					n_shift  = item.tx_byte;
					n_bc     = 4'd0;
					do_enter = 1'b1;
					tgt      = PH_W_BIT;
				end
				FUNC_READ_ACK, FUNC_READ_NACK: begin
					n_sack   = (item.func == FUNC_READ_ACK);
					n_drv    = 1'b0;
					n_shift  = 8'd0;
					n_bc     = 4'd0;
					do_enter = 1'b1;
					tgt      = PH_R_LO;
				end
				default: ;
			endcase
		end else if (dcnt_q > 8'd1) begin
			n_dcnt = dcnt_q - 8'd1;
		end else if (unit_q != 2'd0) begin
			n_unit = unit_q - 2'd1;
			n_dcnt = ulen;
		end else begin
			do_enter = 1'b1;
			tgt      = successor(phase_q, bc_q);
		end

		if (do_enter) begin
			n_phase = tgt;
			n_dcnt  = ulen;
			n_unit  = (tgt inside {PH_S_B, PH_P_A, PH_P_C, PH_R_LO, PH_R_HI}) ? 2'd1 : 2'd0;
			case (tgt)
				PH_S_A: begin
					n_drv = 1'b1;
					n_sda = 1'b1;
					if (!item.sda_in) begin
						n_phase = PH_IDLE;
						done    = 1'b1;
					end else begin
						n_scl = 1'b1;
					end
				end
				PH_S_B: begin
					n_sda = 1'b0;
					if (item.sda_in) begin
						n_phase = PH_IDLE;
						done    = 1'b1;
					end
				end
				PH_S_C: begin
					n_scl   = 1'b0;
					n_phase = PH_IDLE;
					done    = 1'b1;
					okv     = 1'b1;
				end
				PH_P_A: begin
					n_drv = 1'b1;
					n_scl = 1'b0;
					n_sda = 1'b0;
				end
				PH_P_B: n_scl = 1'b1;
				PH_P_C: n_sda = 1'b1;
				PH_P_D: begin
					n_phase = PH_IDLE;
					done    = 1'b1;
					okv     = sack_q;
				end
				PH_W_BIT: begin
					n_sda   = n_shift[7];
					n_shift = {n_shift[6:0], 1'b0};
				end
				PH_W_HI: n_scl = 1'b1;
				PH_W_LO: begin
					n_scl = 1'b0;
					n_bc  = bc_q + 4'd1;
				end
				PH_A_REL: begin
					n_drv = 1'b0;
					n_sda = 1'b1;
				end
				PH_A_HI: begin
					n_scl  = 1'b1;
					n_poll = 8'd0;
				end
				PH_A_POLL: begin
					if (!item.sda_in) begin
						n_scl   = 1'b0;
						n_phase = PH_IDLE;
						done    = 1'b1;
						okv     = 1'b1;
					end else if (poll_q >= cfg.ack_timeout) begin
						// give up: fall into the stop sequence, reported as a failure
						n_sack  = 1'b0;
						n_phase = PH_P_A;
						n_unit  = 2'd1;
						n_drv   = 1'b1;
						n_scl   = 1'b0;
						n_sda   = 1'b0;
					end else begin
						n_poll = poll_q + 8'd1;
					end
				end
				PH_R_LO: n_scl = 1'b0;
				PH_R_HI: begin
					n_scl   = 1'b1;
					n_shift = {shift_q[6:0], item.sda_in};
					n_bc    = bc_q + 4'd1;
				end
				PH_K_DATA: begin
					n_scl = 1'b0;
					n_drv = 1'b1;
					n_sda = !sack_q;
				end
				PH_K_HI: n_scl = 1'b1;
				PH_K_END: begin
					n_scl   = 1'b0;
					rx      = shift_q;
					n_phase = PH_IDLE;
					done    = 1'b1;
					okv     = 1'b1;
				end
				default: n_phase = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bc_q    <= 4'd0;
			shift_q <= 8'd0;
			dcnt_q  <= 8'd0;
			unit_q  <= 2'd0;
			poll_q  <= 8'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			drv_q   <= 1'b1;
			sack_q  <= 1'b0;
		end else if (step) begin
			phase_q <= n_phase;
			bc_q    <= n_bc;
			shift_q <= n_shift;
			dcnt_q  <= n_dcnt;
			unit_q  <= n_unit;
			poll_q  <= n_poll;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			drv_q   <= n_drv;
			sack_q  <= n_sack;
		end
	end

	assign res.scl_out   = n_scl;
	assign res.sda_out   = n_sda;
	assign res.sda_drive = n_drv;
	assign res.busy_res  = (n_phase != PH_IDLE);
	assign res.done_res  = done;
	assign res.ok        = okv;
	assign res.rx_byte   = rx;
endmodule
